// File: hdl/smx_pkg.sv
// Shared types and codes for the stack machine executor.
// Used by smx_alu, stack_machine_executor and tb_top; depends on nothing.
package smx_pkg;

  typedef enum logic [2:0] {
    OP_PUSH_IMM = 3'd0,
    OP_PUSH_MEM = 3'd1,
    OP_POP_MEM  = 3'd2,
    OP_ADD      = 3'd3,
    OP_SUB      = 3'd4,
    OP_MUL      = 3'd5,
    OP_DIV      = 3'd6,
    OP_PRINT    = 3'd7
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2,
    ST_DIVZERO   = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    ALU_ADD = 2'd0,
    ALU_SUB = 2'd1,
    ALU_MUL = 2'd2,
    ALU_DIV = 2'd3
  } alu_op_t;

  typedef struct packed {
    logic    start;
    alu_op_t op;
  } alu_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } alu_sts_t;

endpackage

// File: hdl/smx_alu.sv
// Shared arithmetic unit: add, subtract and multiply in a single registered step, signed
// divide one quotient bit per cycle, then a sign fix state. Depends on smx_pkg.
module smx_alu
  import smx_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  alu_ctl_t    ctl,
  input  logic [31:0] a,
  input  logic [31:0] b,
  output alu_sts_t    sts,
  output logic [31:0] result
);

  typedef enum logic [1:0] {A_IDLE, A_DIV, A_FIX} astate_t;

  astate_t     state;
  logic        done;
  logic [31:0] rem;
  logic [31:0] quo;
  logic [31:0] dvs;
  logic        neg;
  logic [4:0]  cnt;
  logic [32:0] trial;

  // restoring step: shift in next dividend bit, try subtracting divisor
  assign trial = {rem, quo[31]} - {1'b0, dvs};

  assign sts = '{busy: (state != A_IDLE), done: done};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= A_IDLE;
      done  <= 1'b0;
    end else begin
      unique case (state)
        A_IDLE: begin
          done <= ctl.start && (ctl.op != ALU_DIV);
          if (ctl.start) begin
            unique case (ctl.op)
              ALU_ADD: begin
                result <= a + b;
              end
              ALU_SUB: begin
                result <= a - b;
              end
              ALU_MUL: begin
                result <= a * b;
              end
              ALU_DIV: begin
                quo   <= a[31] ? (32'd0 - a) : a;
                dvs   <= b[31] ? (32'd0 - b) : b;
                neg   <= a[31] ^ b[31];
                rem   <= '0;
                cnt   <= '0;
                state <= A_DIV;
              end
              default: ;
            endcase
          end
        end
        A_DIV: begin
          done <= 1'b0;
          if (!trial[32]) begin
            rem <= trial[31:0];
          end else begin
            rem <= {rem[30:0], quo[31]};
          end
          quo <= {quo[30:0], ~trial[32]};
          cnt <= cnt + 5'd1;
          if (cnt == 5'd31) begin
            state <= A_FIX;
          end
        end
        A_FIX: begin
          result <= neg ? (32'd0 - quo) : quo;
          done   <= 1'b1;
          state  <= A_IDLE;
        end
        default: begin
          done  <= 1'b0;
          state <= A_IDLE;
        end
      endcase
    end
  end

endmodule

// File: hdl/stack_machine_executor.sv
// Stack machine executor top level: sequencer, operand stack, data memory
// and output register. Depends on smx_pkg and smx_alu.
//
//   channel  dir  tdata                          tuser        tlast
//   s_*      in   immediate, mem_address         opcode       program_end
//   m_*      out  status, print_value            print_valid  program_done
//
// Push imm passes S_EXEC and S_DONE, push mem adds S_MRD, pops add S_SRD, and
// add/sub/mul/div add S_RDB, S_RDA and a wait in S_ALU; the serial divider in smx_alu sets the worst case.
// After reset the data memory is zeroed one word a cycle, and s_tready stays low meanwhile.
// s_tready is high only while the sequencer idles; a result waiting on
// m_tready does not block intake, the next item stalls only at its own end.
module stack_machine_executor
  import smx_pkg::*;
#(
  parameter int STACK_DEPTH = 128,
  parameter int MEM_DEPTH   = 128
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // [31:0] immediate, [38:32] mem_address, rest zero
  input  logic [2:0]  s_tuser,   // [2:0] opcode
  input  logic        s_tlast,   // program_end
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // [1:0] status, [33:2] print_value, rest zero
  output logic        m_tuser,   // print_valid
  output logic        m_tlast    // program_done
);

  localparam int SW  = $clog2(STACK_DEPTH);
  localparam int CW  = $clog2(STACK_DEPTH + 1);
  localparam int MAW = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_EXEC, S_MRD, S_SRD, S_RDB, S_RDA, S_ALU, S_DONE
  } state_t;

  state_t      state;
  logic [CW-1:0] count;
  logic [MAW-1:0] clr_idx;

  opcode_t     op;
  logic [31:0] imm;
  logic [6:0]  addr;
  logic        last;
  logic [31:0] b_reg;
  status_t     res_status;
  logic        res_pvalid;
  logic [31:0] res_pval;

  logic [31:0] stack_mem [STACK_DEPTH];
  logic [31:0] data_mem [MEM_DEPTH];
  logic [31:0] sdata;
  logic [31:0] mdata;

  logic          stk_we;
  logic [SW-1:0] stk_waddr;
  logic [31:0]   stk_wdata;
  logic [SW-1:0] stk_raddr;
  logic          dm_we;
  logic [MAW-1:0] dm_waddr;
  logic [31:0]   dm_wdata;
  logic [MAW-1:0] mem_idx;
  logic          addr_ok;
  logic [CW-1:0] cnt_m1;
  logic [CW-1:0] cnt_m2;

  alu_ctl_t    alu_ctl;
  alu_sts_t    alu_sts;
  logic [31:0] alu_result;

  smx_alu u_alu (
    .clk    (clk),
    .rst    (rst),
    .ctl    (alu_ctl),
    .a      (sdata),
    .b      (b_reg),
    .sts    (alu_sts),
    .result (alu_result)
  );

  assign s_tready = (state == S_IDLE);
  assign cnt_m1   = count - CW'(1);
  assign cnt_m2   = count - CW'(2);
  assign mem_idx  = MAW'(addr);
  assign addr_ok  = (32'(addr) < 32'(MEM_DEPTH));

  // stack read port: top of stack, or the word below it while fetching a
  always_comb begin
    stk_raddr = cnt_m1[SW-1:0];
    if (state == S_RDB) begin
      stk_raddr = cnt_m2[SW-1:0];
    end
  end

  always_comb begin
    stk_we    = 1'b0;
    stk_waddr = count[SW-1:0];
    stk_wdata = imm;
    dm_we     = 1'b0;
    dm_waddr  = mem_idx;
    dm_wdata  = sdata;
    alu_ctl.start = 1'b0;
    alu_ctl.op    = ALU_ADD;
    unique case (state)
      S_CLEAR: begin
        dm_we    = 1'b1;
        dm_waddr = clr_idx;
        dm_wdata = '0;
      end
      S_EXEC: begin
        if (op == OP_PUSH_IMM && count != CW'(STACK_DEPTH)) begin
          stk_we = 1'b1;
        end
      end
      S_MRD: begin
        stk_we    = 1'b1;
        stk_wdata = addr_ok ? mdata : '0;
      end
      S_SRD: begin
        dm_we = (op == OP_POP_MEM) && addr_ok;
      end
      S_RDA: begin
        alu_ctl.start = 1'b1;
        case (op)
          OP_SUB:  alu_ctl.op = ALU_SUB;
          OP_MUL:  alu_ctl.op = ALU_MUL;
          OP_DIV:  alu_ctl.op = ALU_DIV;
          default: alu_ctl.op = ALU_ADD;
        endcase
      end
      S_ALU: begin
        stk_we    = alu_sts.done;
        stk_waddr = cnt_m2[SW-1:0];
        stk_wdata = alu_result;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (stk_we) begin
      stack_mem[stk_waddr] <= stk_wdata;
    end
    sdata <= stack_mem[stk_raddr];
  end

  always_ff @(posedge clk) begin
    if (dm_we) begin
      data_mem[dm_waddr] <= dm_wdata;
    end
    mdata <= data_mem[mem_idx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      count    <= '0;
      clr_idx  <= '0;
      m_tvalid <= 1'b0;
    end else begin
      // S_DONE reloads the output register itself
      if (m_tvalid && m_tready && state != S_DONE) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          clr_idx <= clr_idx + MAW'(1);
          if (clr_idx == MAW'(MEM_DEPTH - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (s_tvalid) begin
            op         <= opcode_t'(s_tuser);
            imm        <= s_tdata[31:0];
            addr       <= s_tdata[38:32];
            last       <= s_tlast;
            res_status <= ST_OK;
            res_pvalid <= 1'b0;
            res_pval   <= '0;
            state      <= S_EXEC;
          end
        end
        S_EXEC: begin
          unique case (op) inside
            OP_PUSH_IMM, OP_PUSH_MEM: begin
              if (count == CW'(STACK_DEPTH)) begin
                res_status <= ST_OVERFLOW;
                state      <= S_DONE;
              end else if (op == OP_PUSH_IMM) begin
                count <= count + CW'(1);
                state <= S_DONE;
              end else begin
                state <= S_MRD;
              end
            end
            OP_POP_MEM, OP_PRINT: begin
              if (count == '0) begin
                res_status <= ST_UNDERFLOW;
                state      <= S_DONE;
              end else begin
                state <= S_SRD;
              end
            end
            default: begin
              if (count < CW'(2)) begin
                res_status <= ST_UNDERFLOW;
                state      <= S_DONE;
              end else begin
                state <= S_RDB;
              end
            end
          endcase
        end
        S_MRD: begin
          count <= count + CW'(1);
          state <= S_DONE;
        end
        S_SRD: begin
          if (op == OP_PRINT) begin
            res_pvalid <= 1'b1;
            res_pval   <= sdata;
          end
          count <= cnt_m1;
          state <= S_DONE;
        end
        S_RDB: begin
          b_reg <= sdata;
          if (op == OP_DIV && sdata == '0) begin
            res_status <= ST_DIVZERO;
            state      <= S_DONE;
          end else begin
            state <= S_RDA;
          end
        end
        S_RDA: begin
          state <= S_ALU;
        end
        S_ALU: begin
          if (alu_sts.done) begin
            count <= cnt_m1;
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {6'd0, res_pval, res_status};
            m_tuser  <= res_pvalid;
            m_tlast  <= last;
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(STACK_DEPTH))
    else $error("stack count beyond depth");

  a_alu_done_wait: assert property (@(posedge clk) disable iff (rst)
    (alu_sts.done || alu_sts.busy) |-> state == S_ALU)
    else $error("alu active with no sequencer waiting");

  a_no_intake_clear: assert property (@(posedge clk) disable iff (rst)
    state == S_CLEAR |-> !s_tready)
    else $error("item taken during memory clear");

  a_print_ok: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser) |-> m_tdata[1:0] == ST_OK)
    else $error("printed value with error status");

  a_load_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(state) == S_DONE)
    else $error("result loaded outside completion");

endmodule

// File: bench/tb_top.sv
// Self-checking bench for stack_machine_executor: directed, stack-full, backpressure and
// random instruction tests against an in-bench model of the stack and data memory.
// Depends on smx_pkg and the executor RTL.
`timescale 1ns / 100ps

module tb_top;
  import smx_pkg::*;

  localparam int STACK_DEPTH = 128;
  localparam int MEM_DEPTH   = 128;

  typedef struct {
    status_t     status;
    logic        printed;
    logic [31:0] value;
    logic        done;
  } instr_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [39:0] s_tdata = '0;   // [31:0] immediate, [38:32] mem_address
  logic [2:0]  s_tuser = '0;   // [2:0] opcode
  logic        s_tlast = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;        // [1:0] status, [33:2] print_value
  logic        m_tuser;
  logic        m_tlast;

  // machine state as the bench sees it
  logic [31:0] stack_words [STACK_DEPTH];
  int          stack_depth = 0;
  logic [31:0] data_words [MEM_DEPTH];

  instr_result_t pending_results[$];
  int            mismatch_count = 0;
  bit            tx_idle_on = 1'b1;
  bit            rx_idle_on = 1'b1;
  int            rx_hold_request = 0;

  stack_machine_executor #(
    .STACK_DEPTH(STACK_DEPTH),
    .MEM_DEPTH  (MEM_DEPTH)
  ) u_top (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .s_tlast (s_tlast),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser),
    .m_tlast (m_tlast)
  );

  always #1 clk = ~clk;

  initial begin
    for (int i = 0; i < MEM_DEPTH; i++) data_words[i] = '0;
    for (int i = 0; i < STACK_DEPTH; i++) stack_words[i] = '0;
  end

  // signed divide, truncating toward zero; min / -1 wraps to min
  function automatic logic [31:0] div_trunc(logic [31:0] a, logic [31:0] b);
    logic [31:0] mag_a, mag_b, quot;
    mag_a = a[31] ? -a : a;
    mag_b = b[31] ? -b : b;
    quot  = mag_a / mag_b;
    return (a[31] ^ b[31]) ? -quot : quot;
  endfunction

  function automatic instr_result_t execute_instr(opcode_t op, logic [31:0] imm,
                                                  logic [6:0] addr, logic last_i);
    instr_result_t res;
    logic [31:0]   a, b, r;
    res.status  = ST_OK;
    res.printed = 1'b0;
    res.value   = '0;
    res.done    = last_i;
    case (op) inside
      OP_PUSH_IMM, OP_PUSH_MEM: begin
        if (stack_depth >= STACK_DEPTH) begin
          res.status = ST_OVERFLOW;
        end else begin
          stack_words[stack_depth] = (op == OP_PUSH_IMM) ? imm : data_words[addr];
          stack_depth++;
        end
      end
      OP_POP_MEM, OP_PRINT: begin
        if (stack_depth == 0) begin
          res.status = ST_UNDERFLOW;
        end else begin
          stack_depth--;
          if (op == OP_POP_MEM) begin
            data_words[addr] = stack_words[stack_depth];
          end else begin
            res.printed = 1'b1;
            res.value   = stack_words[stack_depth];
          end
        end
      end
      default: begin
        if (stack_depth < 2) begin
          res.status = ST_UNDERFLOW;
        end else begin
          b = stack_words[stack_depth - 1];
          a = stack_words[stack_depth - 2];
          case (op)
            OP_ADD:  r = a + b;
            OP_SUB:  r = a - b;
            OP_MUL:  r = a * b;
            default: r = (b == '0) ? '0 : div_trunc(a, b);
          endcase
          if (op == OP_DIV && b == '0) begin
            res.status = ST_DIVZERO;
          end else begin
            stack_depth--;
            stack_words[stack_depth - 1] = r;
          end
        end
      end
    endcase
    return res;
  endfunction

  task automatic send_instr(opcode_t op, logic [31:0] imm, logic [6:0] addr, logic last_i);
    if (tx_idle_on && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {1'b0, addr, imm};
    s_tuser  <= op;
    s_tlast  <= last_i;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    pending_results.push_back(execute_instr(op, imm, addr, last_i));
  endtask

  task automatic wait_drain();
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  // receiver: random stall bursts, plus a long hold when a test asks for one
  initial begin
    int hold;
    forever begin
      @(posedge clk);
      if (rx_hold_request != 0) begin
        hold = rx_hold_request;
        rx_hold_request = 0;
        m_tready <= 1'b0;
        repeat (hold) @(posedge clk);
      end else if (rx_idle_on && $urandom_range(0, 5) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 14)) @(posedge clk);
      end
      m_tready <= 1'b1;
    end
  end

  // result checker
  always @(posedge clk) begin
    instr_result_t exp_res;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result: status %0d print_value %h", m_tdata[1:0], m_tdata[33:2]);
        mismatch_count++;
      end else begin
        exp_res = pending_results.pop_front();
        if (m_tdata[1:0] !== exp_res.status) begin
          $error("status: expected %0d, got %0d", exp_res.status, m_tdata[1:0]);
          mismatch_count++;
        end
        if (m_tuser !== exp_res.printed) begin
          $error("print_valid: expected %0d, got %0d", exp_res.printed, m_tuser);
          mismatch_count++;
        end
        if (m_tdata[33:2] !== exp_res.value) begin
          $error("print_value: expected %h, got %h", exp_res.value, m_tdata[33:2]);
          mismatch_count++;
        end
        if (m_tlast !== exp_res.done) begin
          $error("program_done: expected %0d, got %0d", exp_res.done, m_tlast);
          mismatch_count++;
        end
      end
    end
  end

  function automatic opcode_t pick_op();
    int push_bias;
    if ($urandom_range(0, 99) < 5) return opcode_t'($urandom_range(0, 7));
    push_bias = (stack_depth < 3) ? 70 : (stack_depth > 20) ? 10 : 35;
    if ($urandom_range(0, 99) < push_bias)
      return ($urandom_range(0, 3) == 0) ? OP_PUSH_MEM : OP_PUSH_IMM;
    case ($urandom_range(0, 5))
      0:       return OP_POP_MEM;
      1:       return OP_ADD;
      2:       return OP_SUB;
      3:       return OP_MUL;
      4:       return OP_DIV;
      default: return OP_PRINT;
    endcase
  endfunction

  function automatic logic [31:0] pick_imm();
    case ($urandom_range(0, 9)) inside
      [0:4]:   return $urandom();
      [5:7]:   return $urandom_range(0, 32) - 16;
      8:       return '0;
      default: begin
        case ($urandom_range(0, 3))
          0:       return 32'h8000_0000;
          1:       return 32'h7FFF_FFFF;
          2:       return 32'hFFFF_FFFF;
          default: return 32'h0000_0001;
        endcase
      end
    endcase
  endfunction

  function automatic logic [6:0] pick_addr();
    return ($urandom_range(0, 1) == 0) ? 7'($urandom_range(0, 127)) : 7'($urandom_range(0, 7));
  endfunction

  task automatic test_random_program(int n_items);
    for (int i = 0; i < n_items; i++)
      send_instr(pick_op(), pick_imm(), pick_addr(), $urandom_range(0, 9) == 0);
  endtask

  task automatic test_directed();
    send_instr(OP_PRINT,    '0, 7'd0, 1'b0);               // underflow on empty stack
    send_instr(OP_POP_MEM,  '0, 7'd0, 1'b0);
    send_instr(OP_ADD,      '0, 7'd0, 1'b0);
    send_instr(OP_PUSH_MEM, '0, 7'd127, 1'b0);             // memory reads zero after reset
    send_instr(OP_SUB,      '0, 7'd0, 1'b0);               // one entry only
    send_instr(OP_PRINT,    '0, 7'd0, 1'b0);
    send_instr(OP_PUSH_IMM, 32'h7FFF_FFFF, 7'd0, 1'b0);
    send_instr(OP_PUSH_IMM, 32'h0000_0001, 7'd0, 1'b0);
    send_instr(OP_ADD,      '0, 7'd0, 1'b0);               // wraps to min
    send_instr(OP_PUSH_IMM, 32'hFFFF_FFFF, 7'd0, 1'b0);
    send_instr(OP_DIV,      '0, 7'd0, 1'b0);               // min / -1
    send_instr(OP_POP_MEM,  '0, 7'd127, 1'b0);
    send_instr(OP_PUSH_MEM, '0, 7'd127, 1'b0);
    send_instr(OP_PUSH_IMM, 32'hFFFF_FFF9, 7'd0, 1'b0);
    send_instr(OP_MUL,      '0, 7'd0, 1'b0);
    send_instr(OP_PUSH_IMM, 32'h0000_0000, 7'd0, 1'b0);
    send_instr(OP_DIV,      '0, 7'd0, 1'b0);               // divide by zero, stack kept
    send_instr(OP_SUB,      '0, 7'd0, 1'b0);
    send_instr(OP_POP_MEM,  '0, 7'd0, 1'b0);
    send_instr(OP_PUSH_IMM, 32'hFFFF_FFF9, 7'd0, 1'b0);
    send_instr(OP_PUSH_IMM, 32'h0000_0002, 7'd0, 1'b0);
    send_instr(OP_DIV,      '0, 7'd0, 1'b0);               // -7 / 2 truncates to -3
    send_instr(OP_PUSH_MEM, '0, 7'd0, 1'b0);
    send_instr(OP_PRINT,    '0, 7'd0, 1'b0);
    send_instr(OP_PRINT,    '0, 7'd0, 1'b1);
    wait_drain();
  endtask

  // fill the stack, push past the top, multiply and refill, then empty it and pop once more
  task automatic test_stack_full();
    while (stack_depth < STACK_DEPTH)
      send_instr($urandom_range(0, 4) == 0 ? OP_PUSH_MEM : OP_PUSH_IMM,
                 pick_imm(), pick_addr(), $urandom_range(0, 9) == 0);
    send_instr(OP_PUSH_IMM, pick_imm(), pick_addr(), 1'b0);
    send_instr(OP_PUSH_MEM, pick_imm(), pick_addr(), 1'b0);
    send_instr(OP_MUL, '0, 7'd0, 1'b0);
    send_instr(OP_PUSH_IMM, pick_imm(), pick_addr(), 1'b0);
    while (stack_depth > 0)
      send_instr($urandom_range(0, 1) == 0 ? OP_PRINT : OP_POP_MEM,
                 '0, pick_addr(), $urandom_range(0, 9) == 0);
    send_instr(OP_PRINT, '0, 7'd0, 1'b1);
    wait_drain();
  endtask

  task automatic test_backpressure();
    tx_idle_on = 1'b0;
    rx_hold_request = 400;
    test_random_program(40);
    wait_drain();
    tx_idle_on = 1'b1;
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_stack_full();
    test_random_program(200);
    wait_drain();
    test_backpressure();
    test_random_program(200);
    wait_drain();
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    test_random_program(100);
    wait_drain();
    if (mismatch_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule

// File: sim.f
hdl/smx_pkg.sv
hdl/smx_alu.sv
hdl/stack_machine_executor.sv
bench/tb_top.sv
